FILE: hw/rtl/cartridge_real_time_clock_assert.svh
// Assertion helpers for the cartridge clock. Expects i_clk and i_rst_n in scope.
`ifndef CARTRIDGE_REAL_TIME_CLOCK_ASSERT_SVH
`define CARTRIDGE_REAL_TIME_CLOCK_ASSERT_SVH

// Condition holds at every edge out of reset.
`define CRTC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("crtc invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define CRTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crtc next-cycle check failed");

`endif

FILE: hw/rtl/crtc_pkg.sv
`default_nettype none

package crtc_pkg;

    // item operation codes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_LATCH = 2'd1;
    localparam logic [1:0] MODE_REGWR = 2'd2;

    // clock register selects
    localparam logic [3:0] SEL_SECONDS = 4'd8;
    localparam logic [3:0] SEL_MINUTES = 4'd9;
    localparam logic [3:0] SEL_HOURS   = 4'd10;
    localparam logic [3:0] SEL_DAYS    = 4'd11;
    localparam logic [3:0] SEL_FLAGS   = 4'd12;

    localparam int FLAG_DAY_HI = 0;
    localparam int FLAG_STOP   = 6;
    localparam int FLAG_OVF    = 7;

    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int DAYS_PER_WRAP = 365;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic [3:0] reg_select;
    } t_in;

    typedef struct packed {
        logic [7:0] latched_seconds;
        logic [7:0] latched_minutes;
        logic [7:0] latched_hours;
        logic [8:0] latched_days;
        logic [7:0] latched_flags;
    } t_out;

    // byte mod 60 by three conditional subtracts
    function automatic logic [5:0] mod60_u8(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd240) r = r - 8'd240;
        if (r >= 8'd120) r = r - 8'd120;
        if (r >= 8'd60)  r = r - 8'd60;
        return r[5:0];
    endfunction

    // byte mod 24 by four conditional subtracts
    function automatic logic [4:0] mod24_u8(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        return r[4:0];
    endfunction

    // 9-bit value is below twice 365, so one subtract is enough
    function automatic logic [8:0] mod365_u9(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (r >= 9'(DAYS_PER_WRAP)) r = r - 9'(DAYS_PER_WRAP);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cartridge_real_time_clock.sv
// Cartridge real-time clock with latched register bank.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat is a tick,
// a latch port write or a clock register write, chosen by mode.
// Output channel (o_out_valid / i_out_ready / o_out_data): one beat per
// input beat, carrying the latched bank as it stands after that item.
// An accepted input beat passes through the input register, then the
// update into the state/bank registers (which also serve as the result
// register).
// Throughput: one beat per cycle unless the output stalls; every item is
// one combinational counter-cascade update, input register to state.
// Receiver stall: the result holds; the input register still takes one
// more beat, then o_in_ready drops until the output drains.
// Reset (i_rst_n low at a clock edge): all time fields, flags, the latch
// edge memory and the bank clear to zero, both stages empty.
`default_nettype none

module cartridge_real_time_clock #(
    parameter int TICKS_PER_SECOND = 60
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire crtc_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output crtc_pkg::t_out      o_out_data
);

    logic          r_in_valid;
    crtc_pkg::t_in r_in_data;
    logic          r_out_valid;
    logic          w_adv;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    crtc_core #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (r_in_valid && w_adv),
        .i_item (r_in_data),
        .o_bank (o_out_data)
    );

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/crtc_core.sv
`default_nettype none

module crtc_core #(
    parameter int TICKS_PER_SECOND = 60
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire crtc_pkg::t_in i_item,
    output crtc_pkg::t_out     o_bank
);

    `include "cartridge_real_time_clock_assert.svh"

    localparam logic [5:0] TPS = 6'(TICKS_PER_SECOND);

    logic [5:0] r_tick, n_tick;
    logic [5:0] r_sec,  n_sec;
    logic [5:0] r_min,  n_min;
    logic [4:0] r_hour, n_hour;
    logic [8:0] r_days, n_days;
    logic [7:0] r_flags, n_flags;
    logic       r_prev_latch, n_prev_latch;
    crtc_pkg::t_out r_bank, n_bank;

    always_comb begin
        n_tick       = r_tick;
        n_sec        = r_sec;
        n_min        = r_min;
        n_hour       = r_hour;
        n_days       = r_days;
        n_flags      = r_flags;
        n_prev_latch = r_prev_latch;
        n_bank       = r_bank;
        case (i_item.mode)
            crtc_pkg::MODE_TICK: begin
                if (!r_flags[crtc_pkg::FLAG_STOP]) begin
                    n_tick = r_tick + 6'd1;
                    if (n_tick >= TPS) begin
                        n_tick = '0;
                        if (r_sec < 6'(crtc_pkg::SECS_PER_MIN - 1)) begin
                            n_sec = r_sec + 6'd1;
                        end else begin
                            n_sec = '0;
                            if (r_min < 6'(crtc_pkg::MINS_PER_HOUR - 1)) begin
                                n_min = r_min + 6'd1;
                            end else begin
                                n_min = '0;
                                if (r_hour < 5'(crtc_pkg::HOURS_PER_DAY - 1)) begin
                                    n_hour = r_hour + 5'd1;
                                end else begin
                                    n_hour = '0;
                                    if (r_days < 9'(crtc_pkg::DAYS_PER_WRAP - 1)) begin
                                        n_days = r_days + 9'd1;
                                    end else begin
                                        n_days = '0;
                                        n_flags[crtc_pkg::FLAG_OVF] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            crtc_pkg::MODE_LATCH: begin
                n_prev_latch = i_item.data[0];
                // copy on a rising bit 0 only
                if (i_item.data[0] && !r_prev_latch) begin
                    n_bank.latched_seconds = 8'(r_sec);
                    n_bank.latched_minutes = 8'(r_min);
                    n_bank.latched_hours   = 8'(r_hour);
                    n_bank.latched_days    = r_days;
                    n_bank.latched_flags   = r_flags;
                end
            end
            crtc_pkg::MODE_REGWR: begin
                case (i_item.reg_select)
                    crtc_pkg::SEL_SECONDS: begin
                        n_bank.latched_seconds = i_item.data;
                        n_sec = crtc_pkg::mod60_u8(i_item.data);
                    end
                    crtc_pkg::SEL_MINUTES: begin
                        n_bank.latched_minutes = i_item.data;
                        n_min = crtc_pkg::mod60_u8(i_item.data);
                    end
                    crtc_pkg::SEL_HOURS: begin
                        n_bank.latched_hours = i_item.data;
                        n_hour = crtc_pkg::mod24_u8(i_item.data);
                    end
                    crtc_pkg::SEL_DAYS: begin
                        n_bank.latched_days = 9'(i_item.data);
                        n_days = crtc_pkg::mod365_u9({r_days[8], i_item.data});
                    end
                    crtc_pkg::SEL_FLAGS: begin
                        n_bank.latched_flags = i_item.data;
                        n_flags = i_item.data;
                        n_days = crtc_pkg::mod365_u9(
                            {i_item.data[crtc_pkg::FLAG_DAY_HI], r_days[7:0]});
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_sec        <= '0;
            r_min        <= '0;
            r_hour       <= '0;
            r_days       <= '0;
            r_flags      <= '0;
            r_prev_latch <= 1'b0;
            r_bank       <= '0;
        end else if (i_en) begin
            r_tick       <= n_tick;
            r_sec        <= n_sec;
            r_min        <= n_min;
            r_hour       <= n_hour;
            r_days       <= n_days;
            r_flags      <= n_flags;
            r_prev_latch <= n_prev_latch;
            r_bank       <= n_bank;
        end
    end

    assign o_bank = r_bank;

    `CRTC_ASSERT_ALWAYS(a_tick_range, r_tick < TPS)
    `CRTC_ASSERT_ALWAYS(a_time_range,
        (r_sec < 6'(crtc_pkg::SECS_PER_MIN)) && (r_min < 6'(crtc_pkg::MINS_PER_HOUR)))
    `CRTC_ASSERT_ALWAYS(a_day_range,
        (r_hour < 5'(crtc_pkg::HOURS_PER_DAY)) && (r_days < 9'(crtc_pkg::DAYS_PER_WRAP)))
    `CRTC_ASSERT_NEXT(a_latch_edge_hold,
        !(i_en && (i_item.mode == crtc_pkg::MODE_LATCH)), $stable(r_prev_latch))

endmodule

`default_nettype wire

FILE: dv/cartridge_real_time_clock_test.sv
`timescale 1ns / 1ps

module cartridge_real_time_clock_test;

    localparam int TICKS_PER_SEC = 60;
    localparam int RANDOM_ITEMS  = 900;
    localparam int STALL_LIMIT   = 1000;

    localparam logic [1:0] MODE_NONE     = 2'd3;
    localparam logic [3:0] SEL_UNUSED_LO = 4'd0;
    localparam logic [3:0] SEL_UNUSED_HI = 4'd15;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    crtc_pkg::t_in  i_in_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    crtc_pkg::t_out o_out_data;

    cartridge_real_time_clock #(
        .TICKS_PER_SECOND(TICKS_PER_SEC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predicted clock state
    logic [5:0] live_ticks = '0;
    logic [5:0] live_secs  = '0;
    logic [5:0] live_mins  = '0;
    logic [4:0] live_hrs   = '0;
    logic [8:0] live_days  = '0;
    logic [7:0] live_flags = '0;
    logic       latch_prev = 1'b0;
    logic [8:0] shadow_bank [5] = '{default: '0};

    crtc_pkg::t_in  pending_items [$];
    crtc_pkg::t_out bank_expect [$];
    int   useful_items = 0;
    int   in_beats     = 0;
    int   mismatches   = 0;
    int   idle_cycles  = 0;
    logic in_beat_seen = 1'b0;
    logic steady;

    // no idling on either side for a while
    assign steady = (in_beats >= 300) && (in_beats < 500);

    function automatic crtc_pkg::t_out clock_predict(input crtc_pkg::t_in item);
        int   day_word;
        crtc_pkg::t_out bank_view;
        case (item.mode)
            crtc_pkg::MODE_TICK: begin
                if (!live_flags[crtc_pkg::FLAG_STOP]) begin
                    live_ticks = live_ticks + 6'd1;
                    if (live_ticks >= TICKS_PER_SEC) begin
                        live_ticks = '0;
                        if (live_secs == crtc_pkg::SECS_PER_MIN - 1) begin
                            live_secs = '0;
                            if (live_mins == crtc_pkg::MINS_PER_HOUR - 1) begin
                                live_mins = '0;
                                if (live_hrs == crtc_pkg::HOURS_PER_DAY - 1) begin
                                    live_hrs = '0;
                                    if (live_days >= crtc_pkg::DAYS_PER_WRAP - 1) begin
                                        live_days = '0;
                                        live_flags[crtc_pkg::FLAG_OVF] = 1'b1;
                                    end else
                                        live_days = live_days + 9'd1;
                                end else
                                    live_hrs = live_hrs + 5'd1;
                            end else
                                live_mins = live_mins + 6'd1;
                        end else
                            live_secs = live_secs + 6'd1;
                    end
                end
            end
            crtc_pkg::MODE_LATCH: begin
                if (item.data[0] && !latch_prev) begin
                    shadow_bank[0] = {3'b0, live_secs};
                    shadow_bank[1] = {3'b0, live_mins};
                    shadow_bank[2] = {4'b0, live_hrs};
                    shadow_bank[3] = live_days;
                    shadow_bank[4] = {1'b0, live_flags};
                end
                latch_prev = item.data[0];
            end
            crtc_pkg::MODE_REGWR: begin
                case (item.reg_select)
                    crtc_pkg::SEL_SECONDS: begin
                        shadow_bank[0] = {1'b0, item.data};
                        live_secs = 6'(int'(item.data) % crtc_pkg::SECS_PER_MIN);
                    end
                    crtc_pkg::SEL_MINUTES: begin
                        shadow_bank[1] = {1'b0, item.data};
                        live_mins = 6'(int'(item.data) % crtc_pkg::MINS_PER_HOUR);
                    end
                    crtc_pkg::SEL_HOURS: begin
                        shadow_bank[2] = {1'b0, item.data};
                        live_hrs = 5'(int'(item.data) % crtc_pkg::HOURS_PER_DAY);
                    end
                    crtc_pkg::SEL_DAYS: begin
                        shadow_bank[3] = {1'b0, item.data};
                        day_word = int'({live_days[8], item.data}) % crtc_pkg::DAYS_PER_WRAP;
                        live_days = 9'(day_word);
                    end
                    crtc_pkg::SEL_FLAGS: begin
                        shadow_bank[4] = {1'b0, item.data};
                        live_flags = item.data;
                        day_word = int'({item.data[crtc_pkg::FLAG_DAY_HI], live_days[7:0]})
                                   % crtc_pkg::DAYS_PER_WRAP;
                        live_days = 9'(day_word);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        bank_view.latched_seconds = shadow_bank[0][7:0];
        bank_view.latched_minutes = shadow_bank[1][7:0];
        bank_view.latched_hours   = shadow_bank[2][7:0];
        bank_view.latched_days    = shadow_bank[3];
        bank_view.latched_flags   = shadow_bank[4][7:0];
        return bank_view;
    endfunction

    task automatic add_item(input logic [1:0] mode, input logic [7:0] data,
                            input logic [3:0] sel);
        crtc_pkg::t_in item;
        item.mode       = mode;
        item.data       = data;
        item.reg_select = sel;
        pending_items.push_back(item);
        if (mode != MODE_NONE &&
            !(mode == crtc_pkg::MODE_REGWR &&
              (sel < crtc_pkg::SEL_SECONDS || sel > crtc_pkg::SEL_FLAGS)))
            useful_items++;
    endtask

    // falling then rising bit 0 on the latch port
    task automatic queue_latch_pulse();
        add_item(crtc_pkg::MODE_LATCH, {7'($urandom), 1'b0}, 4'($urandom));
        add_item(crtc_pkg::MODE_LATCH, {7'($urandom), 1'b1}, 4'($urandom));
    endtask

    task automatic check_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || in_beat_seen) begin
                if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front();
                end else
                    i_in_valid <= 1'b0;
            end
            i_out_ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge i_clk) begin : monitor
        crtc_pkg::t_out want;
        if (!i_rst_n) begin
            in_beat_seen <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (bank_expect.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat expected none, got %h",
                             $time, o_out_data);
                end else begin
                    want = bank_expect.pop_front();
                    check_field("latched_seconds", 9'(want.latched_seconds),
                                9'(o_out_data.latched_seconds));
                    check_field("latched_minutes", 9'(want.latched_minutes),
                                9'(o_out_data.latched_minutes));
                    check_field("latched_hours", 9'(want.latched_hours),
                                9'(o_out_data.latched_hours));
                    check_field("latched_days", want.latched_days,
                                o_out_data.latched_days);
                    check_field("latched_flags", 9'(want.latched_flags),
                                9'(o_out_data.latched_flags));
                end
            end
            if (i_in_valid && o_in_ready) begin
                bank_expect.push_back(clock_predict(i_in_data));
                in_beats++;
            end
            in_beat_seen <= i_in_valid && o_in_ready;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : stimulus
        int         s;
        int         m;
        int         h;
        int         d;
        int         k;
        int         remaining;
        int         burst;
        logic [7:0] flag_byte;

        // directed: ignored fields, latch edges, raw byte writes, stop,
        // unused selects and mode, day high bit
        add_item(crtc_pkg::MODE_TICK, 8'hff, SEL_UNUSED_HI);
        add_item(crtc_pkg::MODE_LATCH, 8'h01, SEL_UNUSED_HI);
        add_item(crtc_pkg::MODE_LATCH, 8'hff, crtc_pkg::SEL_SECONDS);
        add_item(crtc_pkg::MODE_LATCH, 8'hfe, SEL_UNUSED_LO);
        add_item(crtc_pkg::MODE_REGWR, 8'hff, crtc_pkg::SEL_SECONDS);
        add_item(crtc_pkg::MODE_REGWR, 8'hff, crtc_pkg::SEL_MINUTES);
        add_item(crtc_pkg::MODE_REGWR, 8'hff, crtc_pkg::SEL_HOURS);
        add_item(crtc_pkg::MODE_REGWR, 8'hff, crtc_pkg::SEL_DAYS);
        add_item(crtc_pkg::MODE_REGWR, 8'h01, crtc_pkg::SEL_FLAGS);
        add_item(crtc_pkg::MODE_LATCH, 8'h01, SEL_UNUSED_LO);
        add_item(crtc_pkg::MODE_REGWR, 8'h40, crtc_pkg::SEL_FLAGS);
        add_item(crtc_pkg::MODE_TICK, 8'h00, SEL_UNUSED_LO);
        add_item(crtc_pkg::MODE_TICK, 8'haa, crtc_pkg::SEL_FLAGS);
        add_item(crtc_pkg::MODE_REGWR, 8'h55, SEL_UNUSED_LO);
        add_item(crtc_pkg::MODE_REGWR, 8'haa, crtc_pkg::SEL_SECONDS - 4'd1);
        add_item(crtc_pkg::MODE_REGWR, 8'h33, crtc_pkg::SEL_FLAGS + 4'd1);
        add_item(crtc_pkg::MODE_REGWR, 8'hcc, SEL_UNUSED_HI);
        add_item(MODE_NONE, 8'hff, crtc_pkg::SEL_SECONDS);
        add_item(crtc_pkg::MODE_REGWR, 8'h80, crtc_pkg::SEL_FLAGS);
        add_item(crtc_pkg::MODE_REGWR, 8'h00, crtc_pkg::SEL_SECONDS);
        add_item(crtc_pkg::MODE_TICK, 8'h00, SEL_UNUSED_LO);
        add_item(crtc_pkg::MODE_LATCH, 8'h00, SEL_UNUSED_LO);
        add_item(crtc_pkg::MODE_LATCH, 8'h03, SEL_UNUSED_HI);
        add_item(crtc_pkg::MODE_REGWR, 8'h00, crtc_pkg::SEL_DAYS);
        add_item(crtc_pkg::MODE_REGWR, 8'h00, crtc_pkg::SEL_FLAGS);

        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // park the time just short of a carry, then tick through it
                    s = ($urandom_range(0, 3) != 0) ? crtc_pkg::SECS_PER_MIN - 1
                        : $urandom_range(0, crtc_pkg::SECS_PER_MIN - 1);
                    k = $urandom_range(0, (255 - s) / crtc_pkg::SECS_PER_MIN);
                    add_item(crtc_pkg::MODE_REGWR, 8'(s + k * crtc_pkg::SECS_PER_MIN),
                             crtc_pkg::SEL_SECONDS);
                    m = ($urandom_range(0, 3) != 0) ? crtc_pkg::MINS_PER_HOUR - 1
                        : $urandom_range(0, crtc_pkg::MINS_PER_HOUR - 1);
                    k = $urandom_range(0, (255 - m) / crtc_pkg::MINS_PER_HOUR);
                    add_item(crtc_pkg::MODE_REGWR, 8'(m + k * crtc_pkg::MINS_PER_HOUR),
                             crtc_pkg::SEL_MINUTES);
                    h = ($urandom_range(0, 3) != 0) ? crtc_pkg::HOURS_PER_DAY - 1
                        : $urandom_range(0, crtc_pkg::HOURS_PER_DAY - 1);
                    k = $urandom_range(0, (255 - h) / crtc_pkg::HOURS_PER_DAY);
                    add_item(crtc_pkg::MODE_REGWR, 8'(h + k * crtc_pkg::HOURS_PER_DAY),
                             crtc_pkg::SEL_HOURS);
                    d = ($urandom_range(0, 1) != 0) ? crtc_pkg::DAYS_PER_WRAP - 1
                        : $urandom_range(0, crtc_pkg::DAYS_PER_WRAP - 1);
                    flag_byte = 8'($urandom);
                    flag_byte[crtc_pkg::FLAG_STOP]   = 1'b0;
                    flag_byte[crtc_pkg::FLAG_DAY_HI] = d[8];
                    add_item(crtc_pkg::MODE_REGWR, d[7:0], crtc_pkg::SEL_DAYS);
                    add_item(crtc_pkg::MODE_REGWR, flag_byte, crtc_pkg::SEL_FLAGS);
                    queue_latch_pulse();
                    remaining = $urandom_range(60, 100);
                    while (remaining > 0) begin
                        burst = $urandom_range(1, 40);
                        if (burst > remaining)
                            burst = remaining;
                        repeat (burst)
                            add_item(crtc_pkg::MODE_TICK, 8'($urandom), 4'($urandom));
                        remaining -= burst;
                        queue_latch_pulse();
                    end
                end
                3, 4: begin
                    repeat ($urandom_range(1, 3)) queue_latch_pulse();
                    add_item(crtc_pkg::MODE_LATCH, 8'($urandom), 4'($urandom));
                end
                5, 6: begin
                    add_item(crtc_pkg::MODE_REGWR, 8'($urandom),
                             4'($urandom_range(crtc_pkg::SEL_SECONDS, crtc_pkg::SEL_FLAGS)));
                end
                7: begin
                    flag_byte = 8'($urandom);
                    flag_byte[crtc_pkg::FLAG_STOP] = 1'b1;
                    add_item(crtc_pkg::MODE_REGWR, flag_byte, crtc_pkg::SEL_FLAGS);
                    repeat ($urandom_range(1, 8))
                        add_item(crtc_pkg::MODE_TICK, 8'($urandom), 4'($urandom));
                    queue_latch_pulse();
                    flag_byte[crtc_pkg::FLAG_STOP] = 1'b0;
                    add_item(crtc_pkg::MODE_REGWR, flag_byte, crtc_pkg::SEL_FLAGS);
                end
                8: begin
                    repeat ($urandom_range(1, 3))
                        add_item(2'($urandom), 8'($urandom), 4'($urandom));
                end
                default: begin
                    repeat ($urandom_range(1, 20))
                        add_item(crtc_pkg::MODE_TICK, 8'($urandom), 4'($urandom));
                end
            endcase
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || bank_expect.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
